/* hdl/pfw_pkg.sv */
`default_nettype none
// shared types, constants and the contrast table of the warped fractal height block
package pfw_pkg;

    localparam int C_TABLE_AW   = 8;
    localparam int C_TABLE_SIZE = 2 ** C_TABLE_AW;
    localparam int C_COORD_W    = C_TABLE_AW + 16;
    localparam int C_NOISE_W    = 20;
    localparam int C_MAX_OCT    = 8;
    localparam int C_OCT_W      = $clog2(C_MAX_OCT + 1);
    localparam int C_ROM_DEPTH  = 1024;
    localparam int C_ROM_LOG    = $clog2(C_ROM_DEPTH);
    localparam int C_ROM_AW     = C_ROM_LOG + 1;
    localparam int C_ROM_SH     = 16 - C_ROM_LOG;
    localparam int C_ROM_W      = 17;

    typedef struct packed {
        logic                  en;
        logic [C_TABLE_AW-1:0] addr;
        logic [7:0]            data;
    } t_perm_wr;

    typedef struct packed {
        logic                 start;
        logic [C_COORD_W-1:0] x;
        logic [C_COORD_W-1:0] y;
    } t_noise_req;

    typedef struct packed {
        logic                 done;
        logic [C_NOISE_W-1:0] value;
    } t_noise_rsp;

    typedef logic [C_ROM_W-1:0] t_rom [0:C_ROM_DEPTH];

    function automatic logic [63:0] f_isqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        while (b > n) b = b >> 2;
        while (b != 64'd0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 with 24 fraction bits by repeated squaring of the mantissa
    function automatic logic [63:0] f_log2_q24(input logic [31:0] n);
        int          e;
        logic [63:0] m;
        logic [63:0] res;
        e = 0;
        while (e < 30 && (n >> (e + 1)) != 32'd0) e++;
        m = {32'd0, n} << (30 - e);
        res = 64'(e) << 24;
        for (int bt = 23; bt >= 0; bt--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                res[bt] = 1'b1;
            end
        end
        return res;
    endfunction

    // entry k holds (k / depth) ^ 1.3 in unsigned q1.16
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] es [0:23];
        logic [63:0] ld;
        logic [63:0] lk;
        logic [63:0] mag;
        logic [63:0] p;
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] r;
        ld = f_log2_q24(32'(C_ROM_DEPTH));
        es[0] = 64'd1 << 31;
        for (int j = 1; j < 24; j++) es[j] = f_isqrt(es[j-1] << 32);
        rom[0] = '0;
        for (int k = 1; k <= C_ROM_DEPTH; k++) begin
            lk = f_log2_q24(32'(k));
            mag = (ld > lk) ? ld - lk : 64'd0;
            p = (mag * 64'd13 + 64'd5) / 64'd10;
            whole = p >> 24;
            frac = p & 64'hFF_FFFF;
            r = 64'd1 << 32;
            for (int j = 0; j < 24; j++) begin
                if (frac[j]) r = (r * es[23-j]) >> 32;
            end
            r = (whole >= 64'd33) ? 64'd0 : (r >> whole);
            r = (r + 64'd32768) >> 16;
            rom[k] = (r > 64'd65536) ? C_ROM_W'(65536) : C_ROM_W'(r);
        end
        return rom;
    endfunction

    localparam t_rom C_CONTRAST_ROM = f_build_rom();

endpackage
`default_nettype wire

/* hdl/perlin_fbm_warped_height.sv */
`default_nettype none
// top level: octave sum, domain warp and contrast curve around one noise core
//
//  channel   signals                                          handshake
//  request   i_start i_func i_perm_index i_perm_value
//            i_x_coord i_y_coord                              i_start & !o_busy
//  result    o_height                                         o_valid, one cycle
//  config    i_cfg_index i_cfg_data                           i_cfg_valid & o_cfg_ready
//
//  a table write leaves the block idle; an evaluation holds busy until its result
//  each perlin sample runs in the shared noise core: six reads of the
//  permutation ram plus the fade and blend multiplies
//  reset is synchronous and active low; the permutation ram is not cleared
//  results cannot be held off: o_valid pulses for one cycle, busy is low again then
module perlin_fbm_warped_height
    import pfw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic                 i_func,
    input  wire logic [7:0]           i_perm_index,
    input  wire logic [7:0]           i_perm_value,
    input  wire logic signed [31:0]   i_x_coord,
    input  wire logic signed [31:0]   i_y_coord,
    output logic                      o_valid,
    output logic signed [15:0]        o_height,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [20:0]          i_cfg_data
);

    localparam logic FUNC_EVAL = 1'b1;
    localparam logic FUNC_WRITE = 1'b0;

    localparam logic [2:0] CFG_OCTAVES   = 3'd0;
    localparam logic [2:0] CFG_PERSIST   = 3'd1;
    localparam logic [2:0] CFG_NORM      = 3'd2;
    localparam logic [2:0] CFG_WARP_GAIN = 3'd3;
    localparam logic [2:0] CFG_WARP_OFS  = 3'd4;

    localparam logic [2:0] SMP_QX  = 3'd0;
    localparam logic [2:0] SMP_QY  = 3'd1;
    localparam logic [2:0] SMP_RX  = 3'd2;
    localparam logic [2:0] SMP_RY  = 3'd3;
    localparam logic [2:0] SMP_FIN = 3'd4;

    localparam int C_TOTAL_W = 22;

    typedef enum logic [18:0] {
        T_IDLE  = 19'b000_0000_0000_0000_0001,
        T_OGO   = 19'b000_0000_0000_0000_0010,
        T_OWAIT = 19'b000_0000_0000_0000_0100,
        T_OACC  = 19'b000_0000_0000_0000_1000,
        T_OAMP  = 19'b000_0000_0000_0001_0000,
        T_NORM  = 19'b000_0000_0000_0010_0000,
        T_BASE  = 19'b000_0000_0000_0100_0000,
        T_WARP  = 19'b000_0000_0000_1000_0000,
        T_WGET  = 19'b000_0000_0001_0000_0000,
        T_NGO   = 19'b000_0000_0010_0000_0000,
        T_NWAIT = 19'b000_0000_0100_0000_0000,
        T_SCA   = 19'b000_0000_1000_0000_0000,
        T_SCB   = 19'b000_0001_0000_0000_0000,
        T_SCC   = 19'b000_0010_0000_0000_0000,
        T_VAL   = 19'b000_0100_0000_0000_0000,
        T_RLO   = 19'b000_1000_0000_0000_0000,
        T_RHI   = 19'b001_0000_0000_0000_0000,
        T_RMUL  = 19'b010_0000_0000_0000_0000,
        T_OUT   = 19'b100_0000_0000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    logic [3:0]  r_octaves;
    logic [15:0] r_persist;
    logic [14:0] r_norm;
    logic [15:0] r_wgain;
    logic [20:0] r_wofs;

    logic [31:0]                  r_x, r_y;
    logic [C_OCT_W-1:0]           r_oct_i;
    logic signed [C_TOTAL_W-1:0]  r_total;
    logic [16:0]                  r_amp;
    logic signed [C_TOTAL_W-1:0]  r_base;
    logic signed [C_TOTAL_W-1:0]  r_w;
    logic [2:0]                   r_smp;
    logic signed [C_NOISE_W-1:0]  r_qa, r_qb;
    logic [C_COORD_W-1:0]         r_sa, r_sb;
    logic [16:0]                  r_v;
    logic [C_ROM_W-1:0]           r_lo;
    logic [C_ROM_W-1:0]           r_rom_q;
    logic signed [15:0]           r_height;
    logic signed [43:0]           r_prod;

    logic                         accept;
    logic [C_OCT_W-1:0]           oct_eff;
    logic                         oct_last;
    logic [31:0]                  shx, shy;
    logic [C_COORD_W-1:0]         cx, cy, ofs;
    logic signed [22:0]           mul_a;
    logic signed [20:0]           mul_b;
    logic signed [C_NOISE_W-1:0]  noise_val;
    logic signed [20:0]           vsum;
    logic [C_ROM_AW-1:0]          idx;
    logic [15:0]                  frac;
    logic [C_ROM_AW-1:0]          rom_addr;
    logic [C_ROM_W-1:0]           rom_diff;
    logic [C_ROM_W-1:0]           hv;
    t_perm_wr                     perm_wr;
    t_noise_req                   nreq;
    t_noise_rsp                   nrsp;

    pfw_noise u_noise (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (perm_wr),
        .i_req   (nreq),
        .o_rsp   (nrsp)
    );

    assign o_busy      = (r_state != T_IDLE);
    assign accept      = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_height    = r_height;
    assign noise_val   = $signed(nrsp.value);

    assign perm_wr.en   = accept && (i_func == FUNC_WRITE);
    assign perm_wr.addr = i_perm_index[C_TABLE_AW-1:0];
    assign perm_wr.data = i_perm_value;

    // zero octaves acts as one, too many are capped
    always_comb begin
        if (r_octaves == 4'd0) begin
            oct_eff = C_OCT_W'(1);
        end else if (32'(r_octaves) > C_MAX_OCT) begin
            oct_eff = C_OCT_W'(C_MAX_OCT);
        end else begin
            oct_eff = C_OCT_W'(r_octaves);
        end
    end
    assign oct_last = (r_oct_i + C_OCT_W'(1)) >= oct_eff;

    assign shx = r_x << r_oct_i;
    assign shy = r_y << r_oct_i;
    assign ofs = C_COORD_W'(r_wofs);

    always_comb begin
        cx = shx[C_COORD_W-1:0];
        cy = shy[C_COORD_W-1:0];
        if (r_state == T_NGO) begin
            case (r_smp)
                SMP_QX: begin
                    cx = r_x[C_COORD_W-1:0] + ofs;
                    cy = r_y[C_COORD_W-1:0] + ofs;
                end
                SMP_QY: begin
                    cx = r_x[C_COORD_W-1:0] - ofs;
                    cy = r_y[C_COORD_W-1:0] - ofs;
                end
                SMP_RY: begin
                    cx = r_x[C_COORD_W-1:0] + r_sb;
                    cy = r_y[C_COORD_W-1:0] + r_sa;
                end
                default: begin
                    cx = r_x[C_COORD_W-1:0] + r_sa;
                    cy = r_y[C_COORD_W-1:0] + r_sb;
                end
            endcase
        end
    end

    assign nreq.start = (r_state == T_OGO) || (r_state == T_NGO);
    assign nreq.x     = cx;
    assign nreq.y     = cy;

    // contrast lookup position and interpolation weight
    assign idx      = r_v[16:C_ROM_SH];
    assign frac     = {r_v[C_ROM_SH-1:0], C_ROM_LOG'(0)};
    assign rom_diff = (r_rom_q >= r_lo) ? r_rom_q - r_lo : '0;
    assign hv       = (idx == C_ROM_AW'(C_ROM_DEPTH)) ? r_lo : r_lo + r_prod[32:16];
    assign vsum     = 21'(r_qa >>> 1) + 21'sd32768;

    always_comb begin
        rom_addr = idx;
        if (r_state == T_RHI && idx != C_ROM_AW'(C_ROM_DEPTH)) begin
            rom_addr = idx + 1'b1;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            T_OWAIT: begin
                mul_a = 23'(noise_val);
                mul_b = 21'(r_amp);
            end
            T_OACC: begin
                mul_a = 23'(r_amp);
                mul_b = 21'(r_persist);
            end
            T_NORM: begin
                mul_a = 23'(r_total);
                mul_b = 21'(r_norm);
            end
            T_WARP: begin
                mul_a = 23'(r_base);
                mul_b = 21'(r_wgain);
            end
            T_SCA: begin
                mul_a = 23'(r_w);
                mul_b = 21'(r_qa);
            end
            T_SCB: begin
                mul_a = 23'(r_w);
                mul_b = 21'(r_qb);
            end
            T_RMUL: begin
                mul_a = 23'(rom_diff);
                mul_b = 21'(frac);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            T_IDLE:  if (accept && i_func == FUNC_EVAL) n_state = T_OGO;
            T_OGO:   n_state = T_OWAIT;
            T_OWAIT: if (nrsp.done) n_state = T_OACC;
            T_OACC:  n_state = T_OAMP;
            T_OAMP:  n_state = oct_last ? T_NORM : T_OGO;
            T_NORM:  n_state = T_BASE;
            T_BASE:  n_state = T_WARP;
            T_WARP:  n_state = T_WGET;
            T_WGET:  n_state = T_NGO;
            T_NGO:   n_state = T_NWAIT;
            T_NWAIT: begin
                if (nrsp.done) begin
                    if (r_smp == SMP_FIN) begin
                        n_state = T_VAL;
                    end else if (r_smp == SMP_QY || r_smp == SMP_RY) begin
                        n_state = T_SCA;
                    end else begin
                        n_state = T_NGO;
                    end
                end
            end
            T_SCA:   n_state = T_SCB;
            T_SCB:   n_state = T_SCC;
            T_SCC:   n_state = T_NGO;
            T_VAL:   n_state = T_RLO;
            T_RLO:   n_state = T_RHI;
            T_RHI:   n_state = T_RMUL;
            T_RMUL:  n_state = T_OUT;
            T_OUT:   n_state = T_IDLE;
            default: n_state = T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == T_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octaves <= 4'd5;
            r_persist <= 16'd36045;
            r_norm    <= 15'd15527;
            r_wgain   <= 16'd19661;
            r_wofs    <= 21'd196608;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OCTAVES:   r_octaves <= i_cfg_data[3:0];
                CFG_PERSIST:   r_persist <= i_cfg_data[15:0];
                CFG_NORM:      r_norm    <= i_cfg_data[14:0];
                CFG_WARP_GAIN: r_wgain   <= i_cfg_data[15:0];
                CFG_WARP_OFS:  r_wofs    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_a * mul_b;
        r_rom_q <= C_CONTRAST_ROM[rom_addr];
        unique case (r_state)
            T_IDLE: begin
                if (accept) begin
                    r_x     <= i_x_coord;
                    r_y     <= i_y_coord;
                    r_total <= '0;
                    r_amp   <= 17'd65536;
                    r_oct_i <= '0;
                end
            end
            T_OACC: r_total <= r_total + C_TOTAL_W'(r_prod >>> 16);
            T_OAMP: begin
                r_amp   <= r_prod[32:16];
                r_oct_i <= r_oct_i + C_OCT_W'(1);
            end
            T_BASE: r_base <= C_TOTAL_W'(r_prod >>> 15);
            T_WGET: begin
                r_w   <= C_TOTAL_W'(r_prod >>> 16);
                r_smp <= SMP_QX;
            end
            T_NWAIT: begin
                if (nrsp.done) begin
                    if (!r_smp[0]) begin
                        r_qa <= noise_val;
                    end else begin
                        r_qb <= noise_val;
                    end
                    if (r_smp == SMP_QX || r_smp == SMP_RX) begin
                        r_smp <= r_smp + 3'd1;
                    end
                end
            end
            T_SCB: r_sa <= C_COORD_W'(r_prod >>> 16);
            T_SCC: begin
                r_sb  <= C_COORD_W'(r_prod >>> 16);
                r_smp <= r_smp + 3'd1;
            end
            T_VAL: begin
                if (vsum < 0) begin
                    r_v <= '0;
                end else if (vsum > 21'sd65536) begin
                    r_v <= 17'd65536;
                end else begin
                    r_v <= 17'(vsum);
                end
            end
            T_RHI: r_lo <= r_rom_q;
            T_OUT: begin
                // top of the curve saturates to the largest positive height
                if (hv > C_ROM_W'(65535)) begin
                    r_height <= 16'sd32767;
                end else begin
                    r_height <= 16'(hv - C_ROM_W'(32768));
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/pfw_noise.sv */
`default_nettype none
// 2d perlin noise core around the permutation ram, one shared multiplier
module pfw_noise
    import pfw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_perm_wr   i_wr,
    input  wire t_noise_req i_req,
    output t_noise_rsp      o_rsp
);

    typedef enum logic [10:0] {
        NS_IDLE = 11'b000_0000_0001,
        NS_RP0  = 11'b000_0000_0010,
        NS_RP1  = 11'b000_0000_0100,
        NS_RAA  = 11'b000_0000_1000,
        NS_RAB  = 11'b000_0001_0000,
        NS_RBA  = 11'b000_0010_0000,
        NS_RBB  = 11'b000_0100_0000,
        NS_BL0  = 11'b000_1000_0000,
        NS_BL1  = 11'b001_0000_0000,
        NS_BL2  = 11'b010_0000_0000,
        NS_BL3  = 11'b100_0000_0000
    } t_nstate;

    t_nstate r_state;
    t_nstate n_state;
    logic    r_done;

    logic [7:0]            r_mem [0:C_TABLE_SIZE-1];
    logic [7:0]            r_rdata;
    logic [C_TABLE_AW-1:0] rd_addr;

    logic [C_TABLE_AW-1:0] r_cx, r_cy;
    logic [15:0]           r_fx, r_fy;
    logic [7:0]            r_p0, r_p1, r_aa, r_ab, r_ba, r_bb;
    logic [15:0]           r_t2x, r_t2y, r_t3x, r_t3y;
    logic [19:0]           r_inx, r_iny;
    logic [16:0]           r_u, r_v;
    logic signed [C_NOISE_W-1:0] r_x1;
    logic signed [C_NOISE_W-1:0] r_n;
    logic signed [42:0]    r_prod;

    logic signed [21:0] mul_a;
    logic signed [20:0] mul_b;
    logic [34:0]        six;
    logic [15:0]        fade_t;
    logic [19:0]        inner;
    logic signed [17:0] dx0, dx1, dy0, dy1;
    logic signed [18:0] g_aa, g_ab, g_ba, g_bb;
    logic signed [21:0] sh22;
    logic signed [21:0] x2c;

    function automatic logic signed [18:0] f_grad(input logic [2:0] h,
                                                   input logic signed [17:0] dx,
                                                   input logic signed [17:0] dy);
        logic signed [18:0] u;
        logic signed [18:0] v;
        u = h[2] ? 19'(dy) : 19'(dx);
        v = h[2] ? 19'(dx) : 19'(dy);
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    assign dx0 = $signed({2'b00, r_fx});
    assign dy0 = $signed({2'b00, r_fy});
    assign dx1 = dx0 - 18'sd65536;
    assign dy1 = dy0 - 18'sd65536;
    assign g_aa = f_grad(r_aa[2:0], dx0, dy0);
    assign g_ab = f_grad(r_ab[2:0], dx0, dy1);
    assign g_ba = f_grad(r_ba[2:0], dx1, dy0);
    assign g_bb = f_grad(r_bb[2:0], dx1, dy1);

    assign sh22 = 22'(r_prod >>> 16);
    assign x2c  = 22'(g_ab) + sh22;

    // fade polynomial inner term 6t^2 - 15t + 10 from the t*t product
    assign fade_t = (r_state == NS_RP1) ? r_fx : r_fy;
    assign six    = 35'(r_prod[31:0]) * 35'd6;
    assign inner  = 20'(21'(six[34:16]) + 21'd655360 - 21'(fade_t) * 21'd15);

    always_comb begin
        rd_addr = r_cx;
        mul_a   = '0;
        mul_b   = '0;
        unique case (r_state)
            NS_RP0: begin
                rd_addr = r_cx;
                mul_a = 22'(r_fx);
                mul_b = 21'(r_fx);
            end
            NS_RP1: begin
                rd_addr = r_cx + 1'b1;
                mul_a = 22'(r_fy);
                mul_b = 21'(r_fy);
            end
            NS_RAA: begin
                rd_addr = r_p0 + r_cy;
                mul_a = 22'(r_t2x);
                mul_b = 21'(r_fx);
            end
            NS_RAB: begin
                rd_addr = r_p0 + r_cy + 1'b1;
                mul_a = 22'(r_t2y);
                mul_b = 21'(r_fy);
            end
            NS_RBA: begin
                rd_addr = r_p1 + r_cy;
                mul_a = 22'(r_t3x);
                mul_b = 21'(r_inx);
            end
            NS_RBB: begin
                rd_addr = r_p1 + r_cy + 1'b1;
                mul_a = 22'(r_t3y);
                mul_b = 21'(r_iny);
            end
            NS_BL0: begin
                mul_a = 22'(g_ba) - 22'(g_aa);
                mul_b = 21'(r_u);
            end
            NS_BL1: begin
                mul_a = 22'(g_bb) - 22'(g_ab);
                mul_b = 21'(r_u);
            end
            NS_BL2: begin
                mul_a = x2c - 22'(r_x1);
                mul_b = 21'(r_v);
            end
            default: begin
                rd_addr = r_cx;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            NS_IDLE: if (i_req.start) n_state = NS_RP0;
            NS_RP0:  n_state = NS_RP1;
            NS_RP1:  n_state = NS_RAA;
            NS_RAA:  n_state = NS_RAB;
            NS_RAB:  n_state = NS_RBA;
            NS_RBA:  n_state = NS_RBB;
            NS_RBB:  n_state = NS_BL0;
            NS_BL0:  n_state = NS_BL1;
            NS_BL1:  n_state = NS_BL2;
            NS_BL2:  n_state = NS_BL3;
            NS_BL3:  n_state = NS_IDLE;
            default: n_state = NS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= NS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == NS_BL3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            NS_IDLE: begin
                if (i_req.start) begin
                    r_cx <= i_req.x[C_COORD_W-1:16];
                    r_cy <= i_req.y[C_COORD_W-1:16];
                    r_fx <= i_req.x[15:0];
                    r_fy <= i_req.y[15:0];
                end
            end
            NS_RP0: ;
            NS_RP1: begin
                r_p0  <= r_rdata;
                r_t2x <= r_prod[31:16];
                r_inx <= inner;
            end
            NS_RAA: begin
                r_p1  <= r_rdata;
                r_t2y <= r_prod[31:16];
                r_iny <= inner;
            end
            NS_RAB: begin
                r_aa  <= r_rdata;
                r_t3x <= r_prod[31:16];
            end
            NS_RBA: begin
                r_ab  <= r_rdata;
                r_t3y <= r_prod[31:16];
            end
            NS_RBB: begin
                r_ba <= r_rdata;
                r_u  <= r_prod[32:16];
            end
            NS_BL0: begin
                r_bb <= r_rdata;
                r_v  <= r_prod[32:16];
            end
            NS_BL1: r_x1 <= C_NOISE_W'(22'(g_aa) + sh22);
            NS_BL2: ;
            NS_BL3: r_n <= C_NOISE_W'(22'(r_x1) + sh22);
            default: ;
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_n;

endmodule
`default_nettype wire

/* test/pfw_tb_pkg.sv */
`timescale 1ns / 1ps
// request codes and register indexes shared by the height block testbench
package pfw_tb_pkg;

    typedef enum logic {
        FUNC_PERM_WRITE = 1'b0,
        FUNC_EVALUATE   = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        REG_OCTAVE_COUNT = 3'd0,
        REG_PERSISTENCE  = 3'd1,
        REG_NORM_GAIN    = 3'd2,
        REG_WARP_GAIN    = 3'd3,
        REG_WARP_OFFSET  = 3'd4
    } t_reg_index;

    localparam int C_MAX_OCTAVES = 8;
    localparam int C_CURVE_DEPTH = 1024;

endpackage

/* test/pfw_height_checker.sv */
`timescale 1ns / 1ps
// height checker: predicts every evaluate request and compares the returned heights
module pfw_height_checker
    import pfw_tb_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic               i_func,
    input  wire logic [7:0]         i_perm_index,
    input  wire logic [7:0]         i_perm_value,
    input  wire logic signed [31:0] i_x_coord,
    input  wire logic signed [31:0] i_y_coord,
    input  wire logic               i_valid,
    input  wire logic signed [15:0] i_height,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [20:0]        i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    logic [7:0]        perm [0:255];
    logic [3:0]        octaves;
    logic [15:0]       persist;
    logic [14:0]       norm;
    logic [15:0]       wgain;
    logic [20:0]       woffset;
    longint unsigned   curve [0:C_CURVE_DEPTH];
    logic signed [15:0] heights_due [$];

    function automatic longint unsigned sqrt_u64(input longint unsigned n_in);
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned log2_fix24(input int unsigned n);
        int              e;
        longint unsigned m;
        longint unsigned res;
        e = 0;
        while (e < 30 && (n >> (e + 1)) != 0) e++;
        m = longint'(n) << (30 - e);
        res = longint'(e) << 24;
        for (int bt = 23; bt >= 0; bt--) begin
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                res = res | (64'd1 << bt);
            end
        end
        return res;
    endfunction

    // power 1.3 curve, built the same way the hardware table is specified
    initial begin : build_curve
        longint unsigned roots [0:23];
        longint unsigned ld;
        longint unsigned lk;
        longint unsigned mag;
        longint unsigned p;
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned r;
        ld = log2_fix24(C_CURVE_DEPTH);
        roots[0] = 64'd1 << 31;
        for (int j = 1; j < 24; j++) roots[j] = sqrt_u64(roots[j-1] << 32);
        curve[0] = 0;
        for (int k = 1; k <= C_CURVE_DEPTH; k++) begin
            lk = log2_fix24(k);
            mag = (ld > lk) ? ld - lk : 0;
            p = (mag * 13 + 5) / 10;
            whole = p >> 24;
            frac = p & 64'hFF_FFFF;
            r = 64'd1 << 32;
            for (int j = 0; j < 24; j++)
                if (frac[j]) r = (r * roots[23-j]) >> 32;
            r = (whole >= 33) ? 0 : (r >> whole);
            r = (r + 32768) >> 16;
            curve[k] = (r > 65536) ? 65536 : r;
        end
    end

    function automatic longint fade(input logic [15:0] t);
        longint unsigned tt;
        longint unsigned t2;
        longint unsigned t3;
        longint unsigned inner;
        tt = t;
        t2 = (tt * tt) >> 16;
        t3 = (t2 * tt) >> 16;
        inner = ((6 * tt * tt) >> 16) + 10 * 65536 - 15 * tt;
        return longint'((t3 * inner) >> 16);
    endfunction

    function automatic longint grad(input logic [7:0] h, input longint dx, input longint dy);
        longint a;
        longint b;
        a = (h[2:0] < 4) ? dx : dy;
        b = (h[2:0] < 4) ? dy : dx;
        return (h[0] ? -a : a) + (h[1] ? -b : b);
    endfunction

    function automatic longint lerp(input longint a, input longint b, input longint t);
        return a + (((b - a) * t) >>> 16);
    endfunction

    function automatic longint noise2(input logic [31:0] x, input logic [31:0] y);
        logic [7:0] cx;
        logic [7:0] cy;
        logic [7:0] p0;
        logic [7:0] p1;
        longint     fx;
        longint     fy;
        longint     u;
        longint     v;
        longint     g_aa;
        longint     g_ab;
        longint     g_ba;
        longint     g_bb;
        cx = x[23:16];
        cy = y[23:16];
        fx = x[15:0];
        fy = y[15:0];
        p0 = perm[cx];
        p1 = perm[8'(cx + 8'd1)];
        u = fade(x[15:0]);
        v = fade(y[15:0]);
        g_aa = grad(perm[8'(p0 + cy)], fx, fy);
        g_ab = grad(perm[8'(p0 + cy + 8'd1)], fx, fy - 65536);
        g_ba = grad(perm[8'(p1 + cy)], fx - 65536, fy);
        g_bb = grad(perm[8'(p1 + cy + 8'd1)], fx - 65536, fy - 65536);
        return lerp(lerp(g_aa, g_ba, u), lerp(g_ab, g_bb, u), v);
    endfunction

    function automatic logic [31:0] warp_step(input longint w, input longint q);
        return 32'((w * q) >>> 16);
    endfunction

    function automatic logic signed [15:0] predict_height(input logic [31:0] x,
                                                          input logic [31:0] y);
        int              oct;
        longint          total;
        longint          amp;
        longint          base;
        longint          w;
        longint          qx;
        longint          qy;
        longint          rx;
        longint          ry;
        longint          fin;
        longint          v;
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned hv;
        longint          h;
        oct = (octaves == 0) ? 1 : (octaves > C_MAX_OCTAVES) ? C_MAX_OCTAVES : octaves;
        total = 0;
        amp = 65536;
        for (int i = 0; i < oct; i++) begin
            total += (noise2(x << i, y << i) * amp) >>> 16;
            amp = (amp * longint'(persist)) >> 16;
        end
        base = (total * longint'(norm)) >>> 15;
        w = (base * longint'(wgain)) >>> 16;
        qx = noise2(x + 32'(woffset), y + 32'(woffset));
        qy = noise2(x - 32'(woffset), y - 32'(woffset));
        rx = noise2(x + warp_step(w, qx), y + warp_step(w, qy));
        ry = noise2(x + warp_step(w, qy), y + warp_step(w, qx));
        fin = noise2(x + warp_step(w, rx), y + warp_step(w, ry));
        v = (fin >>> 1) + 32768;
        if (v < 0) v = 0;
        if (v > 65536) v = 65536;
        pos = longint'(v) * C_CURVE_DEPTH;
        idx = pos >> 16;
        frac = pos & 64'hFFFF;
        if (idx >= C_CURVE_DEPTH)
            hv = curve[C_CURVE_DEPTH];
        else if (curve[idx+1] >= curve[idx])
            hv = curve[idx] + (((curve[idx+1] - curve[idx]) * frac) >> 16);
        else
            hv = curve[idx];
        h = longint'(hv) - 32768;
        if (h > 32767) h = 32767;
        return 16'(h);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            octaves <= 4'd5;
            persist <= 16'd36045;
            norm <= 15'd15527;
            wgain <= 16'd19661;
            woffset <= 21'd196608;
            heights_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_index'(i_cfg_index))
                    REG_OCTAVE_COUNT: octaves <= i_cfg_data[3:0];
                    REG_PERSISTENCE:  persist <= i_cfg_data[15:0];
                    REG_NORM_GAIN:    norm <= i_cfg_data[14:0];
                    REG_WARP_GAIN:    wgain <= i_cfg_data[15:0];
                    REG_WARP_OFFSET:  woffset <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (heights_due.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10)
                        $display("unexpected height %0d with no request waiting", i_height);
                end else begin
                    if (heights_due[0] !== i_height) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10)
                            $display("height: expected %0d, got %0d",
                                     heights_due[0], i_height);
                    end
                    void'(heights_due.pop_front());
                end
            end
            // blocking here so a request ending on a result edge is queued after the pop
            if (i_start && !i_busy) begin
                if (t_func'(i_func) == FUNC_PERM_WRITE)
                    perm[i_perm_index] = i_perm_value;
                else
                    heights_due.push_back(predict_height(i_x_coord, i_y_coord));
            end
        end
        o_pending <= heights_due.size();
    end

    initial o_fail_count = 0;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// testbench top: drives requests and register writes, then gives the verdict
module tb_top;
    import pfw_tb_pkg::*;

    localparam int C_IDLE_LIMIT = 5000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic               i_func;
    logic [7:0]         i_perm_index;
    logic [7:0]         i_perm_value;
    logic signed [31:0] i_x_coord;
    logic signed [31:0] i_y_coord;
    logic               o_valid;
    logic signed [15:0] o_height;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [20:0]        i_cfg_data;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    int                 burst_left;
    int                 evals_sent;
    int                 writes_sent;
    int                 heights_seen;

    perlin_fbm_warped_height uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_func(i_func), .i_perm_index(i_perm_index), .i_perm_value(i_perm_value),
        .i_x_coord(i_x_coord), .i_y_coord(i_y_coord), .o_valid(o_valid),
        .o_height(o_height), .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    pfw_height_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_func(i_func), .i_perm_index(i_perm_index), .i_perm_value(i_perm_value),
        .i_x_coord(i_x_coord), .i_y_coord(i_y_coord), .i_valid(o_valid),
        .i_height(o_height), .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (o_valid) heights_seen <= heights_seen + 1;
        if (idle_cycles >= C_IDLE_LIMIT) begin
            $display("perlin_fbm_warped_height: mismatch");
            $finish;
        end
    end

    task automatic send_request(input t_func f, input logic [7:0] idx, input logic [7:0] val,
                                input logic [31:0] x, input logic [31:0] y);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
        burst_left--;
        i_start = 1'b1;
        i_func = f;
        i_perm_index = idx;
        i_perm_value = val;
        i_x_coord = x;
        i_y_coord = y;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
        i_start = 1'b0;
        if (f == FUNC_EVALUATE) evals_sent++;
        else writes_sent++;
    endtask

    task automatic write_reg(input t_reg_index r, input logic [20:0] d);
        i_cfg_valid = 1'b1;
        i_cfg_index = r;
        i_cfg_data = d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0 || o_busy) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic eval_at(input logic [31:0] x, input logic [31:0] y);
        send_request(FUNC_EVALUATE, 8'($urandom), 8'($urandom), x, y);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h00FF, 16'($urandom)};
            default: return {16'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
        endcase
    endfunction

    task automatic random_part(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0)
                send_request(FUNC_PERM_WRITE, 8'($urandom), 8'($urandom),
                             $urandom, $urandom);
            else
                eval_at(pick_coord(), pick_coord());
        end
    endtask

    initial begin
        logic [7:0] shuffled [0:255];
        logic [7:0] tmp;
        int         j;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_func = 1'b0;
        i_perm_index = '0;
        i_perm_value = '0;
        i_x_coord = '0;
        i_y_coord = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        idle_cycles = 0;
        burst_left = 0;
        evals_sent = 0;
        writes_sent = 0;
        heights_seen = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // every table entry is loaded before the first evaluation
        for (int k = 0; k < 256; k++) shuffled[k] = 8'(k);
        for (int k = 255; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = shuffled[k];
            shuffled[k] = shuffled[j];
            shuffled[j] = tmp;
        end
        for (int k = 0; k < 256; k++)
            send_request(FUNC_PERM_WRITE, 8'(k), shuffled[k], $urandom, $urandom);

        // directed corners on the reset settings
        eval_at(32'h0000_0000, 32'h0000_0000);
        eval_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        eval_at(32'h8000_0000, 32'h8000_0000);
        eval_at(32'hFFFF_FFFF, 32'h0000_0000);
        eval_at(32'h00FF_FFFF, 32'h00FF_0000);
        eval_at(32'h0000_FFFF, 32'hFFFF_0001);
        eval_at(32'h0001_8000, 32'h0002_4000);
        send_request(FUNC_PERM_WRITE, 8'hFF, 8'h00, 32'hFFFF_FFFF, 32'h8000_0000);
        send_request(FUNC_PERM_WRITE, 8'h00, 8'hFF, 32'h0000_0000, 32'h7FFF_FFFF);
        eval_at(32'h00FF_8000, 32'h00FF_8000);
        eval_at(32'hFFFF_8000, 32'h0000_8000);
        random_part(290);

        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(REG_OCTAVE_COUNT, 21'd1);
                    write_reg(REG_PERSISTENCE, 21'd0);
                    write_reg(REG_NORM_GAIN, 21'd0);
                    write_reg(REG_WARP_GAIN, 21'd0);
                    write_reg(REG_WARP_OFFSET, 21'd0);
                end
                1: begin
                    write_reg(REG_OCTAVE_COUNT, 21'd8);
                    write_reg(REG_PERSISTENCE, 21'd65535);
                    write_reg(REG_NORM_GAIN, 21'd32767);
                    write_reg(REG_WARP_GAIN, 21'd65535);
                    write_reg(REG_WARP_OFFSET, 21'd1048576);
                end
                2: begin
                    // zero octaves behaves as one
                    write_reg(REG_OCTAVE_COUNT, 21'd0);
                    write_reg(REG_NORM_GAIN, 21'($urandom));
                    write_reg(REG_WARP_OFFSET, 21'h1F_FFFF);
                end
                3: begin
                    // count above the maximum behaves as the maximum
                    write_reg(REG_OCTAVE_COUNT, 21'($urandom) | 21'hF);
                    write_reg(REG_PERSISTENCE, 21'($urandom));
                    write_reg(REG_WARP_GAIN, 21'($urandom));
                end
                default: begin
                    write_reg(REG_OCTAVE_COUNT, 21'($urandom_range(1, 8)));
                    write_reg(REG_PERSISTENCE, 21'($urandom));
                    write_reg(REG_NORM_GAIN, 21'($urandom_range(8000, 32767)));
                    write_reg(REG_WARP_GAIN, 21'($urandom));
                    write_reg(REG_WARP_OFFSET, 21'($urandom));
                end
            endcase
            random_part(207);
        end

        drain();
        repeat (200) @(negedge i_clk);
        $display("covered %0d evaluations and %0d table writes over seven register settings",
                 evals_sent, writes_sent);
        $display("%0d heights returned, %0d failures", heights_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("perlin_fbm_warped_height: match");
        else
            $display("perlin_fbm_warped_height: mismatch");
        $finish;
    end

endmodule

/* files.f */
hdl/pfw_pkg.sv
hdl/pfw_noise.sv
hdl/perlin_fbm_warped_height.sv
test/pfw_tb_pkg.sv
test/pfw_height_checker.sv
test/tb_top.sv
